### src/divisor_sum_classifier_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the divisor sum classifier
// Implication checks on a clock with a synchronous active-high reset.
// ----------------------------------------------------------------------------
`ifndef DIVISOR_SUM_CLASSIFIER_CORE_ASSERT_SVH
`define DIVISOR_SUM_CLASSIFIER_CORE_ASSERT_SVH

// same-cycle implication
`define DSC_ASSERT_SAME(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define DSC_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### src/dsc_pkg.sv
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types and constants of the divisor sum classifier.
// ----------------------------------------------------------------------------
package dsc_pkg;

  localparam int SUM_OUT_W   = 18;
  localparam int COUNT_OUT_W = 8;
  localparam int CLASS_W     = 2;

  localparam logic [SUM_OUT_W-1:0]   SUM_MAX   = {SUM_OUT_W{1'b1}};
  localparam logic [COUNT_OUT_W-1:0] COUNT_MAX = {COUNT_OUT_W{1'b1}};

  localparam logic [CLASS_W-1:0] CLASS_DEFICIENT = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_PERFECT   = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_ABUNDANT  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_ACC,
    ST_FIN
  } dsc_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dsc_div_stat_t;

endpackage

### src/divisor_sum_classifier_core.sv
// ----------------------------------------------------------------------------
// divisor_sum_classifier_core
// Finds the proper divisor sum and divisor count of a number by trial
// division and classifies it as deficient, perfect or abundant.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | tdata fields (lowest bit up)
//  --------+-----+----------------------+------------------------------------
//  s_*     | in  | s_tvalid / s_tready  | number[15:0]
//  m_*     | out | m_tvalid / m_tready  | proper_divisor_sum[17:0],
//          |     |                      | divisor_count[25:18],
//          |     |                      | classification[27:26],
//          |     |                      | input_error[28], zero[31:29]
//
//  One item at a time. Each candidate divisor d = 1, 2, ... goes through
//  start, NW bit-serial divide steps, divider done and accumulate; the walk
//  stops at the first d with n / d < d, NW being min(NUMBER_BITS, 16).
//  A zero input skips the divider and goes straight to ST_FIN.
//  Reset (rst, synchronous) empties the output register and idles the FSM.
//  A stalled result holds in the output register; the next number is
//  taken meanwhile, and its result waits in ST_FIN until the beat clears.
//
module divisor_sum_classifier_core
  import dsc_pkg::*;
#(
  parameter int NUMBER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // number[15:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // sum[17:0], count[25:18], class[27:26], err[28]
);

  // only the low NUMBER_BITS bits of the 16-bit field take part
  localparam int NW  = (NUMBER_BITS < 16) ? NUMBER_BITS : 16;
  // sigma(n) stays below 8n, the count below 2 * 2^(NW/2)
  localparam int SW  = NW + 3;
  localparam int CNW = NW / 2 + 2;
  localparam int XW  = (SW > SUM_OUT_W) ? SW : SUM_OUT_W;
  localparam int XC  = (CNW > COUNT_OUT_W) ? CNW : COUNT_OUT_W;

  dsc_state_t state, state_next;

  logic [NW-1:0]  n_reg;
  logic [NW-1:0]  d_reg;
  logic [SW-1:0]  total;
  logic [CNW-1:0] count;
  logic           err;

  logic [SUM_OUT_W-1:0]   out_sum;
  logic [COUNT_OUT_W-1:0] out_count;
  logic [CLASS_W-1:0]     out_class;
  logic                   out_err;
  logic                   out_valid;

  logic          div_start;
  logic [NW-1:0] div_q;
  logic [NW-1:0] div_r;
  dsc_div_stat_t div_stat;

  logic          in_beat;
  logic          out_load;
  logic [NW-1:0] n_in;

  dsc_divider #(
    .WIDTH (NW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (n_reg),
    .divisor   (d_reg),
    .quotient  (div_q),
    .remainder (div_r),
    .stat      (div_stat)
  );

  assign n_in    = s_tdata[NW-1:0];
  assign in_beat = s_tvalid && s_tready;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = (n_in == '0) ? ST_FIN : ST_START;
        end
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        // past sqrt(n) once the quotient drops below the candidate
        state_next = (div_q < d_reg) ? ST_FIN : ST_START;
      end
      ST_FIN: begin
        // wait for the output register to free up
        if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Accumulate divisor pairs d and n / d
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_beat) begin
      n_reg <= n_in;
      d_reg <= NW'(1);
      total <= '0;
      count <= '0;
      err   <= (n_in == '0);
    end else if ((state == ST_ACC) && (div_q >= d_reg)) begin
      if (div_r == '0) begin
        if (div_q != d_reg) begin
          total <= total + SW'(d_reg) + SW'(div_q);
          count <= count + CNW'(2);
        end else begin
          total <= total + SW'(d_reg);
          count <= count + CNW'(1);
        end
      end
      d_reg <= d_reg + NW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Result: saturate to field widths, classify on the exact sum
  // --------------------------------------------------------------------------
  logic [SW-1:0]          proper;
  logic [XW-1:0]          proper_x;
  logic [XC-1:0]          count_x;
  logic [SUM_OUT_W-1:0]   sum_sat;
  logic [COUNT_OUT_W-1:0] count_sat;
  logic [CLASS_W-1:0]     cls;

  always_comb begin
    proper    = total - SW'(n_reg);
    proper_x  = XW'(proper);
    count_x   = XC'(count);
    sum_sat   = (proper_x > XW'(SUM_MAX)) ? SUM_MAX : proper_x[SUM_OUT_W-1:0];
    count_sat = (count_x > XC'(COUNT_MAX)) ? COUNT_MAX : count_x[COUNT_OUT_W-1:0];
    if (proper < SW'(n_reg)) begin
      cls = CLASS_DEFICIENT;
    end else if (proper == SW'(n_reg)) begin
      cls = CLASS_PERFECT;
    end else begin
      cls = CLASS_ABUNDANT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // drop all result fields to zero on an error beat
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sum   <= err ? '0 : sum_sat;
      out_count <= err ? '0 : count_sat;
      out_class <= err ? CLASS_DEFICIENT : cls;
      out_err   <= err;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_err, out_class, out_count, out_sum};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "divisor_sum_classifier_core_assert.svh"

  `DSC_ASSERT_SAME(a_done_only_in_div, clk, rst, div_stat.done, state == ST_DIV)
  `DSC_ASSERT_NEXT(a_zero_goes_to_fin, clk, rst, in_beat && (n_in == '0), err && (state == ST_FIN))
  `DSC_ASSERT_SAME(a_err_clears_fields, clk, rst, out_valid && out_err, m_tdata[27:0] == 28'd0)
  `DSC_ASSERT_SAME(a_divisor_nonzero, clk, rst, div_start, (d_reg != '0) && !div_stat.busy)

endmodule

### src/dsc_divider.sv
// ----------------------------------------------------------------------------
// dsc_divider
// Bit-serial restoring divider: one quotient bit per cycle while busy.
// ----------------------------------------------------------------------------
module dsc_divider
  import dsc_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder,
  output dsc_div_stat_t    stat
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH:0]   rem;
  logic [WIDTH-1:0] quo;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;

  logic [WIDTH:0] rem_sh;
  logic [WIDTH:0] rem_sub;
  logic           fits;

  always_comb begin
    rem_sh  = {rem[WIDTH-1:0], quo[WIDTH-1]};
    fits    = (rem_sh >= {1'b0, divisor});
    rem_sub = rem_sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CW'(1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // shift in one dividend bit, restore on a failed subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      cnt <= CW'(WIDTH);
    end else if (busy) begin
      rem <= fits ? rem_sub : rem_sh;
      quo <= {quo[WIDTH-2:0], fits};
      cnt <= cnt - CW'(1);
    end
  end

  assign quotient  = quo;
  assign remainder = rem[WIDTH-1:0];
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
